/* rtl/core/rrts_pkg.sv */
package rrts_pkg;

  localparam logic [15:0] QUANTUM_RESET = 16'd10;

  // operation codes of an input item
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // configuration port
  localparam int          PADDR_W     = 3;
  localparam logic        CFG_QUANTUM = 1'b0;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  typedef struct packed {
    logic        action;
    logic [7:0]  task_id;
    logic [15:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slice_task;
    logic [15:0] slice_length;
    logic [31:0] slice_start;
    logic        task_finished;
    logic [31:0] turnaround_sum;
    logic [31:0] response_sum;
    logic [31:0] wait_sum;
    logic [7:0]  task_count;
  } out_item_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  task_id;
    logic [15:0] burst;
  } cmd_t;

endpackage

/* rtl/core/rrts_front.sv */
module rrts_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rrts_pkg::in_item_t               in_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rrts_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [15:0]                      quantum_eff,
  output rrts_pkg::cmd_t                   cmd,
  output logic                             cmd_valid,
  input  logic                             cmd_pop
);
  import rrts_pkg::*;

  cmd_t                 fifo_r [CMD_DEPTH];
  logic [CMD_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CMD_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CMD_AW:0]      cnt_r, cnt_nxt;
  logic [15:0]          quantum_r, quantum_nxt;
  logic                 push;
  logic                 pop;
  logic                 cfg_wr;
  cmd_t                 cmd_in;

  assign busy      = (cnt_r == (CMD_AW+1)'(CMD_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = fifo_r[rd_ptr_r];

  // classify the incoming beat into a command
  always_comb begin
    cmd_in.op      = in_item.action ? OP_RUN : OP_ADD;
    cmd_in.task_id = in_item.task_id;
    cmd_in.burst   = in_item.burst;
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_QUANTUM);
  assign prdata = (paddr[2] == CFG_QUANTUM) ? {16'd0, quantum_r} : 32'd0;
  // a zero quantum runs as one time unit
  assign quantum_eff = (quantum_r == 16'd0) ? 16'd1 : quantum_r;

  always_comb begin
    wr_ptr_nxt  = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt  = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt     = cnt_r + (CMD_AW+1)'(push) - (CMD_AW+1)'(pop);
    quantum_nxt = cfg_wr ? pwdata[15:0] : quantum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      quantum_r <= QUANTUM_RESET;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      cnt_r     <= cnt_nxt;
      quantum_r <= quantum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/core/rrts_back.sv */
module rrts_back #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           quantum_eff,
  input  rrts_pkg::cmd_t        cmd,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  output logic                  out_valid,
  output rrts_pkg::out_item_t   out_item
);
  import rrts_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] remaining;
    logic [15:0] original;
    logic        started;
  } entry_t;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  entry_t          mem [QUEUE_DEPTH];
  entry_t          rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;

  logic [1:0]      state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [31:0]     clock_r, clock_nxt;
  logic [31:0]     turn_r, turn_nxt;
  logic [31:0]     resp_r, resp_nxt;
  logic [31:0]     fburst_r, fburst_nxt;
  logic [7:0]      acc_r, acc_nxt;
  logic            out_valid_r, out_valid_nxt;

  // slice bookkeeping carried from exec to emit
  logic [7:0]      sl_task_r, sl_task_nxt;
  logic [15:0]     sl_len_r, sl_len_nxt;
  logic [31:0]     sl_start_r, sl_start_nxt;
  logic            sl_fin_r, sl_fin_nxt;
  logic [15:0]     sl_orig_r, sl_orig_nxt;
  out_item_t       out_r, out_nxt;

  logic            full;
  logic            empty;
  logic [15:0]     len;
  logic [15:0]     rem_left;
  logic [31:0]     wait_val;

  assign full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign len       = (rd_data_r.remaining < quantum_eff) ? rd_data_r.remaining : quantum_eff;
  assign rem_left  = rd_data_r.remaining - len;
  assign wait_val  = (turn_r >= fburst_r) ? turn_r - fburst_r : 32'd0;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    clock_nxt     = clock_r;
    turn_nxt      = turn_r;
    resp_nxt      = resp_r;
    fburst_nxt    = fburst_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    sl_task_nxt   = sl_task_r;
    sl_len_nxt    = sl_len_r;
    sl_start_nxt  = sl_start_r;
    sl_fin_nxt    = sl_fin_r;
    sl_orig_nxt   = sl_orig_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;

    out_nxt                = out_r;
    out_nxt.slice_task     = 8'd0;
    out_nxt.slice_length   = 16'd0;
    out_nxt.slice_start    = 32'd0;
    out_nxt.task_finished  = 1'b0;
    out_nxt.turnaround_sum = turn_r;
    out_nxt.response_sum   = resp_r;
    out_nxt.wait_sum       = wait_val;
    out_nxt.task_count     = acc_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_ADD) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_nxt.status = ST_FULL;
            end else begin
              mem_we            = 1'b1;
              mem_wdata.task_id   = cmd.task_id;
              mem_wdata.remaining = cmd.burst;
              mem_wdata.original  = cmd.burst;
              mem_wdata.started   = 1'b0;
              tail_nxt          = ptr_inc(tail_r);
              cnt_nxt           = cnt_r + 1'b1;
              acc_nxt           = (acc_r == 8'hFF) ? acc_r : acc_r + 8'd1;
              out_nxt.status     = ST_ADDED;
              out_nxt.task_count = acc_nxt;
            end
          end else if (empty) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            head_nxt  = ptr_inc(head_r);
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        sl_task_nxt  = rd_data_r.task_id;
        sl_len_nxt   = len;
        sl_start_nxt = clock_r;
        sl_orig_nxt  = rd_data_r.original;
        sl_fin_nxt   = (rem_left == 16'd0);
        clock_nxt    = sat_add(clock_r, {16'd0, len});
        if (!rd_data_r.started) begin
          resp_nxt = sat_add(resp_r, clock_r);
        end
        // work left goes back to the tail
        if (rem_left != 16'd0) begin
          mem_we              = 1'b1;
          mem_wdata.task_id   = rd_data_r.task_id;
          mem_wdata.remaining = rem_left;
          mem_wdata.original  = rd_data_r.original;
          mem_wdata.started   = 1'b1;
          tail_nxt            = ptr_inc(tail_r);
          cnt_nxt             = cnt_r + 1'b1;
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (sl_fin_r) begin
          turn_nxt   = sat_add(turn_r, clock_r);
          fburst_nxt = sat_add(fburst_r, {16'd0, sl_orig_r});
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_nxt.status        = ST_RUN;
        out_nxt.slice_task    = sl_task_r;
        out_nxt.slice_length  = sl_len_r;
        out_nxt.slice_start   = sl_start_r;
        out_nxt.task_finished = sl_fin_r;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      clock_r     <= '0;
      turn_r      <= '0;
      resp_r      <= '0;
      fburst_r    <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      clock_r     <= clock_nxt;
      turn_r      <= turn_nxt;
      resp_r      <= resp_nxt;
      fburst_r    <= fburst_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sl_task_r  <= sl_task_nxt;
    sl_len_r   <= sl_len_nxt;
    sl_start_r <= sl_start_nxt;
    sl_fin_r   <= sl_fin_nxt;
    sl_orig_r  <= sl_orig_nxt;
    out_r      <= out_nxt;
  end

  // ready queue storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[head_r];
    end
  end

endmodule

/* rtl/core/round_robin_task_scheduler.sv */
// channel   ports                                   handshake
// input     start, busy, in_item                    beat taken when start && !busy
// result    out_valid, out_item                     one-cycle strobe, cannot be held off
// config    psel, penable, pwrite, paddr, pwdata,   write on access phase, pready high
//           prdata, pready
//
// a beat lands in a two-entry command queue; the back end drains it one command at a time
// add, reject and empty commands are handled in the idle state; a run slice steps through
// queue memory read, slice update and write-back, total update and result, in that order
// every result is registered: an add, reject or empty result from the idle state,
// a run result from the result step after the total update
// busy rises only while the command queue is full
// rst_n is synchronous; the ready queue contents stay undefined until written
module round_robin_task_scheduler #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rrts_pkg::in_item_t               in_item,
  output logic                             out_valid,
  output rrts_pkg::out_item_t              out_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rrts_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rrts_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;
  logic [15:0] quantum_eff;

  rrts_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .quantum_eff (quantum_eff),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop)
  );

  rrts_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .quantum_eff (quantum_eff),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule

/* rtl/core/rrts_checker.sv */
module rrts_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input rrts_pkg::out_item_t  out_item
);
  import rrts_pkg::*;

  // strobe is clear straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // only a run result carries slice data
  a_no_slice: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_RUN) |->
      (out_item.slice_length == 16'd0 && out_item.task_finished == 1'b0 &&
       out_item.slice_task == 8'd0 && out_item.slice_start == 32'd0))
    else $error("slice fields set on non-run result");

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.wait_sum <= out_item.turnaround_sum))
    else $error("wait sum exceeds turnaround sum");

  a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_ADDED) |-> (out_item.task_count != 8'd0))
    else $error("task added with zero count");

endmodule

bind round_robin_task_scheduler rrts_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_item  (out_item)
);
